[rtl/sppq_pkg.sv]
// ---------------------------------------------------------------------------
// sppq_pkg
// Shared types and constants for the slot priority queue: table geometry,
// entry layout, result codes, controller states and the control bundles
// that pass between the controller and its helper units.
// ---------------------------------------------------------------------------
package sppq_pkg;

  // Table geometry.
  localparam int DEPTH   = 8;
  localparam int SLOT_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int ITEM_W  = 8;
  localparam int PRIO_W  = 16;
  localparam int STAMP_W = 32;

  // Byte returned by a remove on an empty table ('!').
  localparam logic [ITEM_W-1:0] BANG_BYTE = 8'd33;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [CNT_W-1:0]  count_t;

  // One stored entry of the slot table.
  typedef struct packed {
    logic [ITEM_W-1:0]         item;
    logic signed [PRIO_W-1:0]  prio;
    logic [STAMP_W-1:0]        stamp;
  } entry_t;

  // Result codes.
  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_REMOVED  = 2'd1,
    ST_FULL     = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  // Controller states, one-hot.
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_DRAIN = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  // Commands to the free slot stack.
  typedef struct packed {
    logic  pop;
    logic  push;
    slot_t push_slot;
  } stack_cmd_t;

  // Status of the free slot stack.
  typedef struct packed {
    slot_t  top_slot;
    logic   empty;
    count_t count;
  } stack_stat_t;

  // One read result handed to the scan unit.
  typedef struct packed {
    logic   start;
    logic   pend;
    logic   occupied;
    slot_t  slot;
  } scan_ctl_t;

  // Running winner of a remove scan.
  typedef struct packed {
    logic              found;
    slot_t             best_slot;
    logic [ITEM_W-1:0] best_item;
  } scan_res_t;

endpackage

[rtl/sppq_slot_ram.sv]
// ---------------------------------------------------------------------------
// sppq_slot_ram
// Slot table storage: one write port and one read port, with the read
// data registered.
// ---------------------------------------------------------------------------
module sppq_slot_ram (
  input  logic            clk,
  input  logic            we,
  input  sppq_pkg::slot_t waddr,
  input  sppq_pkg::entry_t wdata,
  input  logic            re,
  input  sppq_pkg::slot_t raddr,
  output sppq_pkg::entry_t rdata
);
  import sppq_pkg::*;

  entry_t mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/sppq_free_stack.sv]
// ---------------------------------------------------------------------------
// sppq_free_stack
// Stack of free slot numbers. After reset it holds every slot, with
// slot 0 on top. An insert pops the top slot and a remove pushes the
// freed slot back.
// ---------------------------------------------------------------------------
module sppq_free_stack (
  input  logic                  clk,
  input  logic                  rst,
  input  sppq_pkg::stack_cmd_t  cmd,
  output sppq_pkg::stack_stat_t stat
);
  import sppq_pkg::*;

  slot_t  stack [DEPTH];
  count_t count;
  count_t count_m1;

  assign count_m1 = count - count_t'(1);

  // The top entry sits just below the fill count.
  assign stat.top_slot = stack[count_m1[SLOT_W-1:0]];
  assign stat.empty    = (count == '0);
  assign stat.count    = count;

  // Stack contents; reset loads the slot numbers in descending order.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DEPTH; k++) begin
        stack[k] <= slot_t'(DEPTH - 1 - k);
      end
    end else if (cmd.push) begin
      stack[count[SLOT_W-1:0]] <= cmd.push_slot;
    end
  end

  // Fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= count_t'(DEPTH);
    end else if (cmd.pop) begin
      count <= count_m1;
    end else if (cmd.push) begin
      count <= count + count_t'(1);
    end
  end

endmodule

[rtl/sppq_scan.sv]
// ---------------------------------------------------------------------------
// sppq_scan
// Running minimum of a remove scan. Each read entry of an occupied slot
// is compared with the current winner: lower priority wins, and on equal
// priority the lower arrival stamp wins. Equal keys keep the earlier slot.
// ---------------------------------------------------------------------------
module sppq_scan (
  input  logic                clk,
  input  logic                rst,
  input  sppq_pkg::scan_ctl_t ctl,
  input  sppq_pkg::entry_t    rd_entry,
  output sppq_pkg::scan_res_t res
);
  import sppq_pkg::*;

  logic                      found;
  slot_t                     best_slot;
  logic [ITEM_W-1:0]         best_item;
  logic signed [PRIO_W-1:0]  best_prio;
  logic [STAMP_W-1:0]        best_stamp;
  logic                      better;
  logic                      take;

  // Key comparison: signed priority first, then unsigned stamp.
  always_comb begin
    better = ($signed(rd_entry.prio) < best_prio) ||
             (($signed(rd_entry.prio) == best_prio) && (rd_entry.stamp < best_stamp));
    take   = ctl.pend && ctl.occupied && (!found || better);
  end

  // Winner flag.
  always_ff @(posedge clk) begin
    if (rst || ctl.start) begin
      found <= 1'b0;
    end else if (take) begin
      found <= 1'b1;
    end
  end

  // Winner payload.
  always_ff @(posedge clk) begin
    if (take) begin
      best_slot  <= ctl.slot;
      best_item  <= rd_entry.item;
      best_prio  <= rd_entry.prio;
      best_stamp <= rd_entry.stamp;
    end
  end

  assign res.found     = found;
  assign res.best_slot = best_slot;
  assign res.best_item = best_item;

endmodule

[rtl/slot_priority_queue_fifo_ties_unit.sv]
// ---------------------------------------------------------------------------
// slot_priority_queue_fifo_ties_unit
// Priority queue over a table of slots with first-in order among equal
// priorities.
// ---------------------------------------------------------------------------
// An insert (kind 0) or a refused transaction of either kind writes its
// result to the output register as it is accepted. A remove (kind 1) on
// a non-empty table scans the table: the slot table has a single read
// port, so the scan reads one slot per cycle, the drain state compares
// the last entry, and the winner retires once the output register is free.
// One transaction is in progress at a time; the next one is accepted as soon
// as the controller is idle and the output register can take a result.
// Smaller priority values leave first; among equal priorities the entry
// stamped first leaves first (stamps are 32 bits and wrap).
// ---------------------------------------------------------------------------
module slot_priority_queue_fifo_ties_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            kind,
  input  logic [sppq_pkg::ITEM_W-1:0]     item_in,
  input  logic signed [sppq_pkg::PRIO_W-1:0] priority_in,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [sppq_pkg::ITEM_W-1:0]     item_out,
  output logic [1:0]                      status
);
  import sppq_pkg::*;

  state_t             state;
  state_t             state_next;
  logic [DEPTH-1:0]   slot_valid;
  logic [STAMP_W-1:0] next_stamp;
  slot_t              rd_idx;
  logic               rd_pend;
  slot_t              rd_slot;
  logic               out_free;
  logic               in_accept;
  logic               do_insert;
  logic               do_refuse_full;
  logic               do_refuse_empty;
  logic               do_start;
  logic               do_retire;
  logic               rd_en;
  entry_t             wr_entry;
  entry_t             rd_entry;
  stack_cmd_t         stk_cmd;
  stack_stat_t        stk_stat;
  scan_ctl_t          scan_ctl;
  scan_res_t          scan_res;

  // Handshake.
  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = (state != S_IDLE) || !out_free;
  assign in_accept = in_valid && !in_stall;

  // Decode of the accepted transaction.
  always_comb begin
    do_insert       = in_accept && !kind && !stk_stat.empty;
    do_refuse_full  = in_accept && !kind && stk_stat.empty;
    do_refuse_empty = in_accept && kind && (slot_valid == '0);
    do_start        = in_accept && kind && (slot_valid != '0);
    do_retire       = (state == S_DONE) && out_free;
    rd_en           = (state == S_SCAN);
  end

  // Controller.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (do_start) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (rd_idx == slot_t'(DEPTH - 1)) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (do_retire) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Scan read address and the pipeline tag of the data in flight.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx  <= '0;
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= rd_en;
      if (do_start) begin
        rd_idx <= '0;
      end else if (rd_en) begin
        rd_idx <= rd_idx + slot_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_slot <= rd_idx;
  end

  // Occupancy bits and the arrival stamp counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      next_stamp <= '0;
    end else begin
      if (do_insert) begin
        slot_valid[stk_stat.top_slot] <= 1'b1;
        next_stamp                    <= next_stamp + STAMP_W'(1);
      end
      if (do_retire) begin
        slot_valid[scan_res.best_slot] <= 1'b0;
      end
    end
  end

  // New entry for an insert.
  always_comb begin
    wr_entry.item  = item_in;
    wr_entry.prio  = priority_in;
    wr_entry.stamp = next_stamp + STAMP_W'(1);
  end

  // Free stack commands.
  always_comb begin
    stk_cmd.pop       = do_insert;
    stk_cmd.push      = do_retire;
    stk_cmd.push_slot = scan_res.best_slot;
  end

  // Scan unit controls.
  always_comb begin
    scan_ctl.start    = do_start;
    scan_ctl.pend     = rd_pend;
    scan_ctl.occupied = slot_valid[rd_slot];
    scan_ctl.slot     = rd_slot;
  end

  sppq_slot_ram u_ram (
    .clk   (clk),
    .we    (do_insert),
    .waddr (stk_stat.top_slot),
    .wdata (wr_entry),
    .re    (rd_en),
    .raddr (rd_idx),
    .rdata (rd_entry)
  );

  sppq_free_stack u_stack (
    .clk  (clk),
    .rst  (rst),
    .cmd  (stk_cmd),
    .stat (stk_stat)
  );

  sppq_scan u_scan (
    .clk      (clk),
    .rst      (rst),
    .ctl      (scan_ctl),
    .rd_entry (rd_entry),
    .res      (scan_res)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (do_insert || do_refuse_full || do_refuse_empty || do_retire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_insert) begin
      item_out <= '0;
      status   <= ST_INSERTED;
    end else if (do_refuse_full) begin
      item_out <= '0;
      status   <= ST_FULL;
    end else if (do_refuse_empty) begin
      item_out <= BANG_BYTE;
      status   <= ST_EMPTY;
    end else if (do_retire) begin
      item_out <= scan_res.best_item;
      status   <= ST_REMOVED;
    end
  end

`ifndef NO_ASSERTIONS
  // Every slot is either on the free stack or marked occupied.
  a_slot_balance: assert property (@(posedge clk) disable iff (rst)
    (int'(stk_stat.count) + $countones(slot_valid)) == DEPTH)
    else $error("free count and occupancy disagree");

  // A finished scan always names an occupied slot.
  a_scan_winner: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) |-> (scan_res.found && slot_valid[scan_res.best_slot]))
    else $error("scan finished without an occupied winner");

  // A new result only follows an accepted transaction or a finished scan.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_accept || (state == S_DONE)))
    else $error("result appeared without a source");
`endif

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the slot priority queue. A driver feeds insert and
// remove transactions from a queue of pending work, a predictor tracks the
// slot table and free stack, and a monitor compares every result in order.
// ---------------------------------------------------------------------------
module tb;
  import sppq_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int RANDOM_OPS  = 750;
  localparam int HOLD_CYCLES = 80;

  localparam bit OP_INSERT = 1'b0;
  localparam bit OP_REMOVE = 1'b1;

  // One queued transaction; hold_for_drain keeps it back until nothing is
  // outstanding.
  typedef struct {
    bit                        kind;
    logic [ITEM_W-1:0]         item;
    logic signed [PRIO_W-1:0]  prio;
    bit                        hold_for_drain;
  } pq_op_t;

  typedef struct {
    logic [ITEM_W-1:0] item;
    status_t           status;
  } pq_result_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic                      kind = 1'b0;
  logic [ITEM_W-1:0]         item_in = '0;
  logic signed [PRIO_W-1:0]  priority_in = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [ITEM_W-1:0]         item_out;
  logic [1:0]                status;

  // Shadow copy of the slot table and free stack.
  bit                        shadow_used  [DEPTH];
  logic [ITEM_W-1:0]         shadow_item  [DEPTH];
  logic signed [PRIO_W-1:0]  shadow_prio  [DEPTH];
  logic [STAMP_W-1:0]        shadow_stamp [DEPTH];
  int                        shadow_free  [DEPTH];
  int                        shadow_free_cnt;
  logic [STAMP_W-1:0]        shadow_next_stamp;

  pq_op_t     pending_ops[$];
  pq_result_t expected_results[$];

  int cycle = 0;
  int n_sent = 0;
  int n_done = 0;
  int n_err = 0;
  int n_ins = 0, n_rem = 0, n_full = 0, n_empty = 0;

  wire calm = (cycle >= 2000) && (cycle < 3500);

  slot_priority_queue_fifo_ties_unit u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .kind       (kind),
    .item_in    (item_in),
    .priority_in(priority_in),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .item_out   (item_out),
    .status     (status)
  );

  always #5 clk = ~clk;

  // Apply one transaction to the shadow table and return its result.
  function automatic pq_result_t serve_transaction(input bit op_kind,
                                                   input logic [ITEM_W-1:0] op_item,
                                                   input logic signed [PRIO_W-1:0] op_prio);
    pq_result_t r;
    int         slot;
    int         best;
    bit         found;
    r.item = '0;
    if (op_kind == OP_INSERT) begin
      if (shadow_free_cnt == 0) begin
        r.status = ST_FULL;
      end else begin
        shadow_next_stamp = shadow_next_stamp + 1;
        shadow_free_cnt = shadow_free_cnt - 1;
        slot = shadow_free[shadow_free_cnt];
        shadow_used[slot]  = 1'b1;
        shadow_item[slot]  = op_item;
        shadow_prio[slot]  = op_prio;
        shadow_stamp[slot] = shadow_next_stamp;
        r.status = ST_INSERTED;
      end
    end else begin
      found = 1'b0;
      best = 0;
      for (int i = 0; i < DEPTH; i++) begin
        if (shadow_used[i]) begin
          if (!found) begin
            found = 1'b1;
            best = i;
          end else if (shadow_prio[i] < shadow_prio[best] ||
                       (shadow_prio[i] == shadow_prio[best] &&
                        shadow_stamp[i] < shadow_stamp[best])) begin
            best = i;
          end
        end
      end
      if (!found) begin
        r.item = BANG_BYTE;
        r.status = ST_EMPTY;
      end else begin
        shadow_used[best] = 1'b0;
        shadow_free[shadow_free_cnt] = best;
        shadow_free_cnt = shadow_free_cnt + 1;
        r.item = shadow_item[best];
        r.status = ST_REMOVED;
      end
    end
    return r;
  endfunction

  function automatic void add_op(input bit op_kind, input logic [ITEM_W-1:0] op_item,
                                 input logic signed [PRIO_W-1:0] op_prio,
                                 input bit hold);
    pq_op_t op;
    op.kind = op_kind;
    op.item = op_item;
    op.prio = op_prio;
    op.hold_for_drain = hold;
    pending_ops.push_back(op);
  endfunction

  // Priorities lean toward a narrow band so that ties are common.
  function automatic logic signed [PRIO_W-1:0] pick_priority();
    logic signed [PRIO_W-1:0] p;
    case ($urandom_range(9))
      0, 1, 2, 3: begin
        p = PRIO_W'($urandom_range(4));
        p = p - 16'sd2;
      end
      4: p = $urandom_range(1) ? 16'h7FFF : 16'h8000;
      default: p = PRIO_W'($urandom);
    endcase
    return p;
  endfunction

  // Stimulus, reset and end of run.
  initial begin : stimulus
    int n;
    int seg_len;
    int ins_pct;
    bit hold;
    for (int k = 0; k < DEPTH; k++) begin
      shadow_used[k]  = 1'b0;
      shadow_free[k]  = DEPTH - 1 - k;
    end
    shadow_free_cnt   = DEPTH;
    shadow_next_stamp = '0;

    // Directed part: empty remove, field extremes, a '$' payload, equal
    // priorities, a refused insert on a full table, then a complete drain.
    add_op(OP_REMOVE, 8'h5A, 16'sd0, 1'b0);
    add_op(OP_INSERT, 8'hFF, 16'sh7FFF, 1'b0);
    add_op(OP_INSERT, 8'h00, 16'sh8000, 1'b0);
    add_op(OP_INSERT, 8'h24, 16'sd0, 1'b0);
    add_op(OP_INSERT, 8'h01, -16'sd5, 1'b0);
    add_op(OP_INSERT, 8'h02, -16'sd5, 1'b0);
    add_op(OP_INSERT, 8'h03, -16'sd5, 1'b0);
    add_op(OP_INSERT, 8'h64, 16'sd100, 1'b0);
    add_op(OP_INSERT, 8'hAA, -16'sd1, 1'b0);
    add_op(OP_INSERT, 8'h55, 16'sh8000, 1'b0);
    for (int k = 0; k < DEPTH + 1; k++)
      add_op(OP_REMOVE, 8'hFF, 16'shFFFF, k == 0);

    // Random part in segments that mostly fill, mostly drain, or mix.
    n = 0;
    while (n < RANDOM_OPS) begin
      seg_len = $urandom_range(10, 40);
      case ($urandom_range(2))
        0: ins_pct = 80;
        1: ins_pct = 20;
        default: ins_pct = 50;
      endcase
      hold = ($urandom_range(3) == 0);
      for (int k = 0; k < seg_len; k++) begin
        add_op(($urandom_range(99) < ins_pct) ? OP_INSERT : OP_REMOVE,
               ITEM_W'($urandom_range(255)), pick_priority(), hold && (k == 0));
      end
      n += seg_len;
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    do @(posedge clk);
    while (pending_ops.size() != 0 || in_valid || n_done != n_sent);
    repeat (DEPTH + 10) @(posedge clk);

    $display("Run covered %0d transactions over %0d cycles:", n_sent, cycle);
    $display("  %0d inserts, %0d removes, %0d full refusals, %0d empty refusals.",
             n_ins, n_rem, n_full, n_empty);
    if (n_err == 0 && expected_results.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  // Cycle counter and timeout.
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle >= CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // Driver: predicts each accepted transaction and offers the next one.
  always @(posedge clk) begin : drive
    bit         fire;
    pq_op_t     op;
    pq_result_t res;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      fire = in_valid && !in_stall;
      if (fire) begin
        res = serve_transaction(kind, item_in, priority_in);
        expected_results.push_back(res);
        n_sent <= n_sent + 1;
      end
      if (fire || !in_valid) begin
        if (pending_ops.size() > 0 && (calm || $urandom_range(99) >= 28) &&
            (!pending_ops[0].hold_for_drain || (!fire && n_sent == n_done))) begin
          op = pending_ops.pop_front();
          in_valid    <= 1'b1;
          kind        <= op.kind;
          item_in     <= op.item;
          priority_in <= op.prio;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall: random back-pressure plus a periodic long hold-off.
  always @(posedge clk) begin : receive
    int hold_left;
    if (rst) begin
      out_stall <= 1'b0;
      hold_left = 0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else if (cycle % 2500 == 1200) begin
      out_stall <= 1'b1;
      hold_left = HOLD_CYCLES;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 28);
    end
  end

  // Monitor: compares each accepted result with the oldest expectation.
  always @(posedge clk) begin : check
    pq_result_t want;
    if (!rst && out_valid && !out_stall) begin
      n_done <= n_done + 1;
      case (status)
        ST_INSERTED: n_ins++;
        ST_REMOVED:  n_rem++;
        ST_FULL:     n_full++;
        default:     n_empty++;
      endcase
      if (expected_results.size() == 0) begin
        $error("unexpected result: item_out=%0d status=%0d", item_out, status);
        n_err++;
      end else begin
        want = expected_results.pop_front();
        if (status !== want.status) begin
          $error("status: expected %0d (%s), actual %0d", want.status,
                 want.status.name(), status);
          n_err++;
        end
        if (item_out !== want.item) begin
          $error("item_out: expected %0d, actual %0d", want.item, item_out);
          n_err++;
        end
      end
    end
  end

endmodule
